// ===== src/srfb_pkg.sv =====
// Shared package for the shade radio frame builder.
// Holds frame kinds, register indexes, CRC constants, the queue entry type and
// the template and CRC functions used by the front, queue and back modules.
`default_nettype none

package srfb_pkg;

	localparam int PAYLOAD_BYTES_DEF = 32;
	localparam int FIDX_W            = 5;
	localparam int CFG_IDX_W         = 1;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h755B;
	localparam logic [7:0]  PAD_BYTE = 8'h55;

	localparam logic [1:0] KIND_COMMAND   = 2'd0;
	localparam logic [1:0] KIND_GROUP     = 2'd1;
	localparam logic [1:0] KIND_DUPLICATE = 2'd2;
	localparam logic [1:0] KIND_FAVORITE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RADIO_CODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHADE_CHANNEL = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] action;
		logic [7:0] ctr;
		logic [7:0] nonce;
	} frame_req_t;

	function automatic logic [FIDX_W-1:0] frame_len(input logic [1:0] kind);
		logic [FIDX_W-1:0] len;
		case (kind)
			KIND_COMMAND:   len = 5'd21;
			KIND_GROUP:     len = 5'd14;
			KIND_DUPLICATE: len = 5'd22;
			default:        len = 5'd19;
		endcase
		return len;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] frame_byte(
		input logic [1:0]        kind,
		input logic [FIDX_W-1:0] idx,
		input logic [31:0]       rc,
		input logic [7:0]        chan,
		input logic [7:0]        action,
		input logic [7:0]        ctr,
		input logic [7:0]        nonce
	);
		logic [7:0] b;
		b = 8'h00;
		case (kind)
			KIND_COMMAND: begin
				case (idx)
					5'd0:  b = rc[7:0];
					5'd1:  b = rc[15:8];
					5'd2:  b = 8'hC0;
					5'd3:  b = 8'h11;
					5'd4:  b = 8'h00;
					5'd5:  b = 8'h05;
					5'd6:  b = ctr;
					5'd7:  b = 8'hFF;
					5'd8:  b = 8'hFF;
					5'd9:  b = rc[23:16];
					5'd10: b = rc[31:24];
					5'd11: b = 8'h86;
					5'd12: b = 8'h06;
					5'd13: b = nonce;
					5'd14: b = chan;
					5'd15: b = 8'h00;
					5'd16: b = rc[23:16];
					5'd17: b = rc[31:24];
					5'd18: b = 8'h52;
					5'd19: b = action;
					default: b = 8'h00;
				endcase
			end
			KIND_GROUP: begin
				case (idx)
					5'd0:  b = rc[7:0];
					5'd1:  b = rc[15:8];
					5'd2:  b = 8'hC0;
					5'd3:  b = 8'h0A;
					5'd4:  b = 8'h40;
					5'd5:  b = 8'h05;
					5'd6:  b = ctr;
					5'd7:  b = 8'hFF;
					5'd8:  b = 8'hFF;
					5'd9:  b = rc[23:16];
					5'd10: b = rc[31:24];
					5'd11: b = 8'h08;
					5'd12: b = chan;
					5'd13: b = action;
					default: b = 8'h00;
				endcase
			end
			KIND_DUPLICATE: begin
				case (idx)
					5'd0:  b = 8'hFF;
					5'd1:  b = 8'hFF;
					5'd2:  b = 8'hC0;
					5'd3:  b = 8'h12;
					5'd4:  b = 8'h80;
					5'd5:  b = 8'h0D;
					5'd6:  b = ctr;
					5'd7:  b = 8'hFF;
					5'd8:  b = 8'hFF;
					5'd9:  b = 8'h06;
					5'd10: b = 8'h03;
					5'd11: b = 8'h20;
					5'd12: b = 8'h05;
					5'd13: b = 8'h12;
					5'd14: b = 8'h03;
					5'd15: b = 8'hAC;
					5'd16: b = 8'h56;
					5'd17: b = rc[15:8];
					5'd18: b = rc[7:0];
					5'd19: b = rc[23:16];
					5'd20: b = rc[31:24];
					5'd21: b = 8'hC8;
					default: b = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					5'd0:  b = rc[7:0];
					5'd1:  b = rc[15:8];
					5'd2:  b = 8'hC0;
					5'd3:  b = 8'h0F;
					5'd4:  b = 8'h00;
					5'd5:  b = 8'h05;
					5'd6:  b = ctr;
					5'd7:  b = 8'hFF;
					5'd8:  b = 8'hFF;
					5'd9:  b = rc[23:16];
					5'd10: b = rc[31:24];
					5'd11: b = 8'h86;
					5'd12: b = 8'h04;
					5'd13: b = nonce;
					5'd14: b = rc[23:16];
					5'd15: b = rc[31:24];
					5'd16: b = 8'h63;
					5'd17: b = 8'h49;
					default: b = 8'h00;
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== src/shade_radio_frame_builder.sv =====
// Top level of the shade radio frame builder: configuration registers and wiring
// of front, request queue and back. Depends on srfb_pkg, srfb_front, srfb_queue
// and srfb_back.
//
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   req_type, action_code, random_byte
// out       output     out_valid / out_stall out_byte, last_byte
// cfg       input      cfg_we                cfg_index, cfg_data
//
// Each request yields PAYLOAD_BYTES output transactions, one byte per cycle while
// the output is not stalled; the back end's byte counter sets that figure. A
// two-entry queue lets the front take requests while a payload is still being
// sent. Reset clears the sequence counter, queue, byte counter and configuration
// registers. A stall on the output holds the current byte and pauses the
// payload; the input stalls only while the queue is full.
`default_nettype none

module shade_radio_frame_builder #(
	parameter int PAYLOAD_BYTES = srfb_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     req_type,
	input  wire logic [7:0]                     action_code,
	input  wire logic [7:0]                     random_byte,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last_byte,
	input  wire logic                           cfg_we,
	input  wire logic [srfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);

	logic [31:0] radio_code_q;
	logic [7:0]  shade_channel_q;

	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_nonempty;
	srfb_pkg::frame_req_t push_entry;
	srfb_pkg::frame_req_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radio_code_q    <= 32'd0;
			shade_channel_q <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				srfb_pkg::REG_RADIO_CODE:    radio_code_q    <= cfg_data;
				srfb_pkg::REG_SHADE_CHANNEL: shade_channel_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	srfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.action_code (action_code),
		.random_byte (random_byte),
		.q_full      (q_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	srfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	srfb_back #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_nonempty    (q_nonempty),
		.q_head        (q_head),
		.pop           (pop),
		.radio_code    (radio_code_q),
		.shade_channel (shade_channel_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_byte     (last_byte)
	);

endmodule

`default_nettype wire

// ===== src/srfb_front.sv =====
// Front end of the shade radio frame builder: accepts requests and tags them.
// Assigns the rolling sequence counter and nonce; depends on srfb_pkg.
`default_nettype none

module srfb_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [7:0]         action_code,
	input  wire logic [7:0]         random_byte,
	input  wire logic               q_full,
	output logic                    push,
	output srfb_pkg::frame_req_t    push_entry
);

	logic [7:0] ctr_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_entry.kind   = req_type;
		push_entry.action = action_code;
		push_entry.ctr    = ctr_q;
		push_entry.nonce  = ctr_q + 8'd1 + random_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= 8'd0;
		end else if (push) begin
			ctr_q <= ctr_q + 8'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> ctr_q == $past(ctr_q) + 8'd1)
		else $error("Sequence counter did not advance on an accepted request.");

endmodule

`default_nettype wire

// ===== src/srfb_queue.sv =====
// Two-entry request queue between the front and back of the frame builder.
// Stores srfb_pkg::frame_req_t entries; depends on srfb_pkg.
`default_nettype none

module srfb_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire srfb_pkg::frame_req_t push_entry,
	input  wire logic                 pop,
	output logic                      full,
	output logic                      nonempty,
	output srfb_pkg::frame_req_t      head
);

	srfb_pkg::frame_req_t mem_q [2];
	logic                 wr_q;
	logic                 rd_q;
	logic [1:0]           cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !nonempty))
		else $error("Queue overflow or underflow.");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("Queue count did not follow a lone push.");

endmodule

`default_nettype wire

// ===== src/srfb_back.sv =====
// Back end of the shade radio frame builder: emits pad, body and CRC bytes.
// Walks one queued request per payload with a byte counter; depends on srfb_pkg.
`default_nettype none

module srfb_back #(
	parameter int PAYLOAD_BYTES = srfb_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_nonempty,
	input  wire srfb_pkg::frame_req_t q_head,
	output logic                      pop,
	input  wire logic [31:0]          radio_code,
	input  wire logic [7:0]           shade_channel,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                out_byte,
	output logic                      last_byte
);

	localparam int PW = $clog2(PAYLOAD_BYTES);

	srfb_pkg::frame_req_t cur_q;
	logic                 active_q;
	logic [PW-1:0]        pos_q;
	logic [15:0]          crc_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 last_q;

	logic [PW-1:0] len_w;
	logic [PW-1:0] start_w;
	logic [PW-1:0] rel_w;
	logic          is_pad;
	logic          is_body;
	logic          at_last;
	logic          emit;
	logic [7:0]    body_b;
	logic [7:0]    next_b;

	always_comb begin
		len_w   = PW'(srfb_pkg::frame_len(cur_q.kind));
		start_w = PW'(PAYLOAD_BYTES - 2) - len_w;
		rel_w   = pos_q - start_w;
		is_pad  = pos_q < start_w;
		is_body = !is_pad && (rel_w < len_w);
		at_last = pos_q == PW'(PAYLOAD_BYTES - 1);
		body_b  = srfb_pkg::frame_byte(cur_q.kind, rel_w[srfb_pkg::FIDX_W-1:0], radio_code,
			shade_channel, cur_q.action, cur_q.ctr, cur_q.nonce);
		if (is_pad) begin
			next_b = srfb_pkg::PAD_BYTE;
		end else if (is_body) begin
			next_b = body_b;
		end else if (rel_w == len_w) begin
			next_b = crc_q[15:8];
		end else begin
			next_b = crc_q[7:0];
		end
	end

	assign emit      = active_q && (!out_valid_q || !out_stall);
	assign pop       = q_nonempty && (!active_q || (emit && at_last));
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			out_byte_q <= next_b;
			last_q     <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			crc_q       <= srfb_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (is_body) begin
					crc_q <= srfb_pkg::crc_byte(crc_q, body_b);
				end
				if (at_last) begin
					pos_q    <= '0;
					active_q <= 1'b0;
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
				crc_q    <= srfb_pkg::CRC_INIT;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		emit && at_last |=> pos_q == '0)
		else $error("Byte position did not wrap after the final byte.");

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q && pos_q == '0 |-> crc_q == srfb_pkg::CRC_INIT)
		else $error("CRC not at its initial value at frame start.");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit && !at_last |=> active_q)
		else $error("Frame ended before its final byte.");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for shade_radio_frame_builder: directed table, then random requests.
// Predicts every padded payload byte and CRC in the bench itself; needs srfb_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int PAYLOAD     = srfb_pkg::PAYLOAD_BYTES_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 55;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  action;
		logic [7:0]  rnd;
		logic        lit_en;
		logic [7:0]  lit_ctr;
		logic        cfg_en;
		logic [31:0] rc;
		logic [7:0]  chan;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [7:0]  action_code;
	logic [7:0]  random_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last_byte;
	logic        cfg_we;
	logic [srfb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	out_beat_t   frame_bytes_q [$];
	dir_row_t    dir_q [$];
	logic [31:0] model_rc = 32'd0;
	logic [7:0]  model_chan = 8'h00;
	logic [7:0]  model_seq = 8'h00;
	logic        row_lit_en;
	logic [7:0]  row_lit_ctr;
	int          err_count = 0;
	int          reqs_taken = 0;
	int          cycle_count = 0;
	bit          no_idle;
	int          rx_left = 0;
	bit          rx_stall_now = 1'b0;
	int          rx_hold = 0;
	bit          pressure_done = 1'b0;

	shade_radio_frame_builder #(
		.PAYLOAD_BYTES(PAYLOAD)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.action_code (action_code),
		.random_byte (random_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_byte   (last_byte),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			fb = c[15] ^ b[k];
			c = {c[14:0], 1'b0} ^ (fb ? srfb_pkg::CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void predict_frame(input logic [1:0] kind, input logic [7:0] action,
		input logic [7:0] rnd, input logic lit_en, input logic [7:0] lit_ctr);
		logic [175:0] tpl;
		logic [7:0]   body [0:21];
		logic [7:0]   rc0, rc1, rc2, rc3, nonce;
		logic [15:0]  crc;
		int           len, pad;
		out_beat_t    beat;
		rc0 = model_rc[7:0];
		rc1 = model_rc[15:8];
		rc2 = model_rc[23:16];
		rc3 = model_rc[31:24];
		nonce = model_seq + 8'd1 + rnd;
		case (kind)
			srfb_pkg::KIND_COMMAND: begin
				tpl = 176'h1111C0100005BCFFFF8A9186069901008A9152530000;
				len = 21;
			end
			srfb_pkg::KIND_GROUP: begin
				tpl = 176'h1111C00A400518FFFF8A910803010000000000000000;
				len = 14;
			end
			srfb_pkg::KIND_DUPLICATE: begin
				tpl = 176'hFFFFC012800D67FFFF060320051203AC56DE00EFC8C8;
				len = 22;
			end
			default: begin
				tpl = 176'h1111C00F0005D1FFFFB0518604B8B051634900000000;
				len = 19;
			end
		endcase
		for (int i = 0; i < 22; i++)
			body[i] = tpl[175 - 8 * i -: 8];
		body[6] = model_seq;
		case (kind)
			srfb_pkg::KIND_COMMAND: begin
				body[0] = rc0; body[1] = rc1; body[3] = 8'h11;
				body[9] = rc2; body[10] = rc3; body[13] = nonce; body[14] = model_chan;
				body[16] = rc2; body[17] = rc3; body[19] = action;
			end
			srfb_pkg::KIND_GROUP: begin
				body[0] = rc0; body[1] = rc1; body[9] = rc2; body[10] = rc3;
				body[12] = model_chan; body[13] = action;
			end
			srfb_pkg::KIND_DUPLICATE: begin
				body[17] = rc1; body[18] = rc0; body[19] = rc2; body[20] = rc3;
			end
			default: begin
				body[0] = rc0; body[1] = rc1; body[9] = rc2; body[10] = rc3;
				body[13] = nonce; body[14] = rc2; body[15] = rc3;
			end
		endcase
		crc = srfb_pkg::CRC_INIT;
		for (int i = 0; i < len; i++)
			crc = crc_next(crc, body[i]);
		if (lit_en)
			body[6] = lit_ctr;
		pad = (PAYLOAD > len + 2) ? PAYLOAD - (len + 2) : 0;
		beat.last = 1'b0;
		beat.data = srfb_pkg::PAD_BYTE;
		for (int i = 0; i < pad; i++)
			frame_bytes_q.push_back(beat);
		for (int i = 0; i < len; i++) begin
			beat.data = body[i];
			frame_bytes_q.push_back(beat);
		end
		beat.data = crc[15:8];
		frame_bytes_q.push_back(beat);
		beat.data = crc[7:0];
		beat.last = 1'b1;
		frame_bytes_q.push_back(beat);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		err_count++;
		if (err_count <= 10)
			$display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (frame_bytes_q.size() == 0) begin
					report_mismatch("unexpected byte", 8'h00, out_byte);
				end else begin
					e = frame_bytes_q.pop_front();
					if (out_byte !== e.data)
						report_mismatch("out_byte", e.data, out_byte);
					if (last_byte !== e.last)
						report_mismatch("last_byte", {7'd0, e.last}, {7'd0, last_byte});
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					srfb_pkg::REG_RADIO_CODE:    model_rc = cfg_data;
					srfb_pkg::REG_SHADE_CHANNEL: model_chan = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_frame(req_type, action_code, random_byte, row_lit_en, row_lit_ctr);
				model_seq = model_seq + 8'd1;
				reqs_taken++;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (!pressure_done && !no_idle && reqs_taken >= 60) begin
			pressure_done = 1'b1;
			rx_hold = 399;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_stall_now = ($urandom_range(0, 2) == 0);
				rx_left = $urandom_range(1, 19);
			end
			rx_left--;
			out_stall <= rx_stall_now;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("testbench: errors");
		$finish;
	end

	task automatic send_req(input logic [1:0] kind, input logic [7:0] action,
		input logic [7:0] rnd, input logic lit_en, input logic [7:0] lit_ctr);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		action_code <= action;
		random_byte <= rnd;
		row_lit_en  <= lit_en;
		row_lit_ctr <= lit_ctr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_bytes_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [31:0] rc, input logic [7:0] chan);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= srfb_pkg::REG_RADIO_CODE;
		cfg_data  <= rc;
		@(negedge clk);
		cfg_index <= srfb_pkg::REG_SHADE_CHANNEL;
		cfg_data  <= {24'd0, chan};
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		dir_row_t r;
		logic [31:0] rc;
		logic [7:0]  chan;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		req_type    = srfb_pkg::KIND_COMMAND;
		action_code = 8'h00;
		random_byte = 8'h00;
		cfg_we      = 1'b0;
		cfg_index   = srfb_pkg::REG_RADIO_CODE;
		cfg_data    = 32'd0;
		row_lit_en  = 1'b0;
		row_lit_ctr = 8'h00;
		no_idle     = 1'b0;

		// Registers at reset values; the sequence counter is known from reset.
		dir_q.push_back({srfb_pkg::KIND_COMMAND,   8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_GROUP,     8'hFF, 8'h00, 1'b1, 8'd1, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_DUPLICATE, 8'h00, 8'hFF, 1'b1, 8'd2, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_FAVORITE,  8'hFF, 8'hFF, 1'b1, 8'd3, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_COMMAND,   8'hFF, 8'hFF, 1'b1, 8'd4, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_GROUP,     8'h00, 8'hFF, 1'b1, 8'd5, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_DUPLICATE, 8'hFF, 8'h00, 1'b1, 8'd6, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_FAVORITE,  8'h00, 8'h00, 1'b1, 8'd7, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_COMMAND,   8'hFF, 8'hFF, 1'b0, 8'd0, 1'b1,
			32'hFFFFFFFF, 8'hFF});
		dir_q.push_back({srfb_pkg::KIND_GROUP,     8'hFF, 8'hFF, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_DUPLICATE, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_FAVORITE,  8'h00, 8'hFF, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_COMMAND,   8'h00, 8'h00, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_FAVORITE,  8'hFF, 8'h80, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_COMMAND,   8'h5A, 8'h33, 1'b0, 8'd0, 1'b1,
			32'h04030201, 8'h5A});
		dir_q.push_back({srfb_pkg::KIND_GROUP,     8'hA5, 8'h00, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_DUPLICATE, 8'h12, 8'h34, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});
		dir_q.push_back({srfb_pkg::KIND_FAVORITE,  8'h01, 8'hFE, 1'b0, 8'd0, 1'b0, 32'd0, 8'd0});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_q[i]) begin
			r = dir_q[i];
			if (r.cfg_en) begin
				settle();
				write_cfg(r.rc, r.chan);
			end
			send_req(r.kind, r.action, r.rnd, r.lit_en, r.lit_ctr);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin rc = 32'hFFFFFFFF; chan = 8'h00; end
				1: begin rc = 32'h00000000; chan = 8'hFF; end
				default: begin rc = $urandom; chan = 8'($urandom_range(0, 255)); end
			endcase
			write_cfg(rc, chan);
			if (p == PHASES - 1)
				no_idle = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'b0, 8'h00);
		end

		settle();
		repeat (40) @(posedge clk);
		if (frame_bytes_q.size() != 0)
			report_mismatch("bytes left over", 8'h00, 8'h00);
		if (err_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
